// ===== src/assert_macros.svh =====
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/clbp_pkg.sv =====
// types and constants of the core load balance picker
package clbp_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TEMP = 2'd1;
  localparam logic [1:0] OP_BAL  = 2'd2;

  localparam logic [1:0] REG_CORE_CNT    = 2'd0;
  localparam logic [1:0] REG_HOT_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MIGRATE_PCT = 2'd2;

  localparam logic [5:0] CORE_CNT_RST    = 6'd32;
  localparam logic [7:0] HOT_LIMIT_RST   = 8'd85;
  localparam logic [6:0] MIGRATE_PCT_RST = 7'd20;

  localparam int          CNT_CMP_W = 7;
  localparam logic [30:0] PCT_SCALE = 31'd100;
  localparam logic [2:0]  DIV_TOP   = 3'd6;
  localparam logic [7:0]  TEMP_MAX  = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  core_id;
    logic [23:0] value;
  } in_item_t;

  typedef struct packed {
    logic        migrate;
    logic        pair_found;
    logic [4:0]  busy_idx;
    logic [4:0]  idle_idx;
    logic [23:0] load_hi;
    logic [23:0] load_lo;
    logic [6:0]  imbalance_pct;
    logic [31:0] hot_mask;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic count_ok;
    logic scan_last;
    logic div_last;
  } sts_t;

endpackage

// ===== src/clbp_ctrl.sv =====
// controller fsm: sequences update, scan, multiply, divide and result handoff
module clbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  clbp_pkg::sts_t    sts,
  output clbp_pkg::cmd_t    cmd
);

  clbp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == clbp_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clbp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      clbp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == clbp_pkg::OP_BAL && sts.count_ok) begin
            state_nxt = clbp_pkg::S_SCAN;
          end else begin
            state_nxt = clbp_pkg::S_DONE;
          end
        end
      end
      clbp_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = clbp_pkg::S_DRAIN;
        end
      end
      // last read is still in the compare stage
      clbp_pkg::S_DRAIN: begin
        state_nxt = clbp_pkg::S_MUL;
      end
      clbp_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = clbp_pkg::S_DIV;
      end
      clbp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = clbp_pkg::S_DONE;
        end
      end
      clbp_pkg::S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = clbp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = clbp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

// ===== src/clbp_dpath.sv =====
// datapath: core tables, config registers, scan compare, percent divider, result register
module clbp_dpath #(
  parameter int CORES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  clbp_pkg::in_item_t  in_data,
  input  clbp_pkg::cmd_t      cmd,
  output clbp_pkg::sts_t      sts,
  output clbp_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(CORES);
  localparam int CNT_W = $clog2(CORES + 1);

  // configuration
  logic [5:0] core_cnt_r;
  logic [7:0] hot_limit_r;
  logic [6:0] migrate_pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_cnt_r    <= clbp_pkg::CORE_CNT_RST;
      hot_limit_r   <= clbp_pkg::HOT_LIMIT_RST;
      migrate_pct_r <= clbp_pkg::MIGRATE_PCT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        clbp_pkg::REG_CORE_CNT:    core_cnt_r    <= cfg_data[5:0];
        clbp_pkg::REG_HOT_LIMIT:   hot_limit_r   <= cfg_data;
        clbp_pkg::REG_MIGRATE_PCT: migrate_pct_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // scan length, clamped to the table
  logic [CNT_W-1:0] count;
  always_comb begin
    if (clbp_pkg::CNT_CMP_W'(core_cnt_r) > clbp_pkg::CNT_CMP_W'(CORES)) begin
      count = CNT_W'(CORES);
    end else begin
      count = CNT_W'(core_cnt_r);
    end
  end

  // tables: memories plus per-entry written bits
  logic [23:0]      load_mem [CORES];
  logic [7:0]       temp_mem [CORES];
  logic [CORES-1:0] load_v_r;
  logic [CORES-1:0] temp_v_r;
  logic             id_ok;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_load;
  logic             wr_temp;
  logic [7:0]       temp_sat;

  assign id_ok    = clbp_pkg::CNT_CMP_W'(in_data.core_id) < clbp_pkg::CNT_CMP_W'(CORES);
  assign wr_addr  = in_data.core_id[IDX_W-1:0];
  assign wr_load  = cmd.accept && id_ok && (in_data.op == clbp_pkg::OP_LOAD);
  assign wr_temp  = cmd.accept && id_ok && (in_data.op == clbp_pkg::OP_TEMP);
  assign temp_sat = (in_data.value > 24'(clbp_pkg::TEMP_MAX)) ? clbp_pkg::TEMP_MAX
                                                             : in_data.value[7:0];

  always_ff @(posedge clk) begin
    if (wr_load) begin
      load_mem[wr_addr] <= in_data.value;
    end
    if (wr_temp) begin
      temp_mem[wr_addr] <= temp_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_v_r <= '0;
      temp_v_r <= '0;
    end else begin
      if (wr_load) begin
        load_v_r[wr_addr] <= 1'b1;
      end
      if (wr_temp) begin
        temp_v_r[wr_addr] <= 1'b1;
      end
    end
  end

  // scan address and read stage
  logic [IDX_W-1:0] scan_idx_r;
  logic [23:0]      load_q_r;
  logic [7:0]       temp_q_r;
  logic             pipe_v_r;
  logic [IDX_W-1:0] pipe_idx_r;
  logic             pipe_lv_r;
  logic             pipe_tv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= 1'b0;
    end else begin
      pipe_v_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    if (cmd.scan_step) begin
      load_q_r   <= load_mem[scan_idx_r];
      temp_q_r   <= temp_mem[scan_idx_r];
      pipe_idx_r <= scan_idx_r;
      pipe_lv_r  <= load_v_r[scan_idx_r];
      pipe_tv_r  <= temp_v_r[scan_idx_r];
    end
  end

  // compare stage
  logic [23:0]      ld;
  logic [7:0]       tp;
  logic             act;
  logic [23:0]      max_r, min_r;
  logic [IDX_W-1:0] busy_r, idle_r;
  logic [31:0]      hot_r;
  logic             any_r;

  assign ld  = pipe_lv_r ? load_q_r : '0;
  assign tp  = pipe_tv_r ? temp_q_r : '0;
  assign act = pipe_lv_r || pipe_tv_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      max_r  <= '0;
      min_r  <= '0;
      busy_r <= '0;
      idle_r <= '0;
      hot_r  <= '0;
      any_r  <= 1'b0;
    end else if (pipe_v_r && act) begin
      if (tp >= hot_limit_r) begin
        // cores past bit 31 shift out of the mask
        hot_r <= hot_r | (32'd1 << pipe_idx_r);
      end else begin
        if (ld > max_r) begin
          max_r  <= ld;
          busy_r <= pipe_idx_r;
        end
        if (!any_r || ld < min_r) begin
          min_r  <= ld;
          idle_r <= pipe_idx_r;
        end
        any_r <= 1'b1;
      end
    end
  end

  // percent: (max - min) * 100 / max, one quotient bit a cycle
  logic [30:0] num_r;
  logic [30:0] dsh;
  logic [2:0]  div_k_r;
  logic [6:0]  pct_r;
  logic        pair_r;
  logic        qbit;

  assign dsh  = 31'(max_r) << div_k_r;
  assign qbit = (num_r >= dsh);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pct_r  <= '0;
      pair_r <= 1'b0;
    end else if (cmd.mul) begin
      num_r   <= 31'(max_r - min_r) * clbp_pkg::PCT_SCALE;
      pair_r  <= any_r && (max_r != '0);
      div_k_r <= clbp_pkg::DIV_TOP;
      pct_r   <= '0;
    end else if (cmd.div_step) begin
      if (qbit) begin
        num_r <= num_r - dsh;
      end
      pct_r   <= {pct_r[5:0], qbit};
      div_k_r <= div_k_r - 3'd1;
    end
  end

  assign sts.count_ok  = (count >= CNT_W'(2));
  assign sts.scan_last = (CNT_W'(scan_idx_r) == CNT_W'(count - CNT_W'(1)));
  assign sts.div_last  = (div_k_r == 3'd0);

  // result register
  clbp_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.migrate       <= pair_r && (pct_r >= migrate_pct_r);
      out_r.pair_found    <= pair_r;
      out_r.busy_idx      <= 5'(busy_r);
      out_r.idle_idx      <= 5'(idle_r);
      out_r.load_hi       <= max_r;
      out_r.load_lo       <= min_r;
      out_r.imbalance_pct <= pair_r ? pct_r : '0;
      out_r.hot_mask      <= hot_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== src/core_load_balance_picker_top.sv =====
// core load balance picker top: one request in flight, result held until it is taken
// update, unused op or balance with a core count below 2: no scan, the result loads from the done state
// balance: after accept the fsm scans count cores (count = core count clamped to CORES):
// one registered table read per core, a drain state, a multiply and a 7-step divide
// next request accepted in the cycle after the result loads
// sync reset marks all cores inactive, so they read as zero load and temperature; registers 32, 85, 20
`include "assert_macros.svh"

module core_load_balance_picker_top #(
  parameter int CORES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clbp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  clbp_pkg::cmd_t cmd;
  clbp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  clbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  clbp_dpath #(
    .CORES (CORES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  `ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_no_result_overwrite, cmd.load_out, !out_valid || out_ready)
  `ASSERT_IMP(a_pct_range, out_valid, out_data.imbalance_pct <= 7'd100)
  `ASSERT_IMP(a_migrate_needs_pair, out_valid && out_data.migrate, out_data.pair_found)

endmodule
